@@ rtl/core/lss_pkg.sv @@
// Shared operation codes, status codes and default sizes of the LIFO stack with search.
`default_nettype none

package lss_pkg;

  localparam int unsigned DEPTH_DEF     = 256;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned IO_KEY_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned COUNT_W  = 9;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4,
    OP_COUNT  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/lss_ram.sv @@
// Stack entry memory: one write port, one read port with registered read data.
`default_nettype none

module lss_ram #(
  parameter int unsigned DEPTH     = lss_pkg::DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = lss_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic signed [KEY_WIDTH-1:0]  wr_data,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic signed [KEY_WIDTH-1:0]       rd_data
);

  logic signed [KEY_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lifo_stack_with_search_unit.sv @@
// Top level of the LIFO stack of signed keys with top-down search.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+-------------------------
//  request | in_func, in_key                               | start high, busy low
//  result  | out_status, out_data, out_position, out_count | out_valid, one cycle
//
// Push, clear, count, unused codes and operations on an empty stack give
// their result in the cycle after acceptance and never raise busy. Pop and
// peek first read the top entry from the memory, then present it. A search
// reads one entry per cycle from the top down through the single memory
// read port. Busy stays high until the result word is out.
// Reset (rst_n low, synchronous) empties the stack; the memory is not cleared,
// since only entries below the fill count are ever read. The receiver cannot
// stall: each result word is shown for exactly one cycle under out_valid.
// Only one operation is in flight, so a read never meets a write to the same
// entry and the memory needs no forwarding.
`default_nettype none

module lifo_stack_with_search_unit #(
  parameter int unsigned DEPTH     = lss_pkg::DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = lss_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [lss_pkg::FUNC_W-1:0]           in_func,
  input  wire logic signed [lss_pkg::IO_KEY_W-1:0]  in_key,
  output logic                                      out_valid,
  output logic [lss_pkg::STATUS_W-1:0]              out_status,
  output logic signed [lss_pkg::IO_KEY_W-1:0]       out_data,
  output logic [lss_pkg::POS_W-1:0]                 out_position,
  output logic [lss_pkg::COUNT_W-1:0]               out_count
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SRCH
  } state_t;

  state_t                          state_r;
  lss_pkg::op_t                    func_r;
  logic signed [KEY_WIDTH-1:0]     key_r;
  logic [CNT_W-1:0]                count_r;
  logic [AW-1:0]                   pos_r;
  logic [AW-1:0]                   next_addr_r;
  logic                            out_valid_r;
  lss_pkg::status_t                status_r;
  logic signed [lss_pkg::IO_KEY_W-1:0] data_r;
  logic [lss_pkg::POS_W-1:0]       position_r;

  logic                            accept;
  logic                            full;
  logic                            empty;
  logic signed [KEY_WIDTH-1:0]     key_w;
  logic [CNT_W-1:0]                count_m1;
  logic [CNT_W-1:0]                count_m2;
  logic                            mem_wr_en;
  logic                            mem_rd_en;
  logic [AW-1:0]                   mem_rd_addr;
  logic signed [KEY_WIDTH-1:0]     mem_rd_data;
  logic                            hit;
  logic                            last;
  logic                            first_rd;

  // Sign-extend or truncate the request key to the stored width.
  assign key_w    = KEY_WIDTH'(in_key);
  assign accept   = start && !busy;
  assign full     = (count_r == DEPTH_C);
  assign empty    = (count_r == '0);
  assign count_m1 = count_r - CNT_W'(1);
  assign count_m2 = count_r - CNT_W'(2);

  // Compare the word that arrived from the memory this cycle.
  assign hit  = (mem_rd_data == key_r);
  assign last = (pos_r == count_m1[AW-1:0]);

  // First read of pop, peek or search goes out at acceptance.
  assign first_rd = accept && !empty &&
                    (in_func == lss_pkg::OP_POP || in_func == lss_pkg::OP_PEEK ||
                     in_func == lss_pkg::OP_SEARCH);

  assign mem_wr_en   = accept && (in_func == lss_pkg::OP_PUSH) && !full;
  assign mem_rd_en   = first_rd || (state_r == S_SRCH && !hit && !last);
  assign mem_rd_addr = (state_r == S_SRCH) ? next_addr_r : count_m1[AW-1:0];

  lss_ram #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (key_w),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r     <= lss_pkg::op_t'(in_func);
            key_r      <= key_w;
            status_r   <= lss_pkg::ST_OK;
            data_r     <= '0;
            position_r <= '0;
            unique case (in_func)
              lss_pkg::OP_PUSH: begin
                if (full) begin
                  status_r <= lss_pkg::ST_FULL;
                end else begin
                  count_r <= count_r + CNT_W'(1);
                end
                out_valid_r <= 1'b1;
              end
              lss_pkg::OP_POP, lss_pkg::OP_PEEK: begin
                if (empty) begin
                  status_r    <= lss_pkg::ST_EMPTY;
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= S_READ;
                end
              end
              lss_pkg::OP_CLEAR: begin
                count_r     <= '0;
                out_valid_r <= 1'b1;
              end
              lss_pkg::OP_SEARCH: begin
                if (empty) begin
                  status_r    <= lss_pkg::ST_NOTFOUND;
                  out_valid_r <= 1'b1;
                end else begin
                  pos_r       <= '0;
                  next_addr_r <= count_m2[AW-1:0];
                  state_r     <= S_SRCH;
                end
              end
              default: begin
                // count and unused codes: report the count, change nothing
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          data_r <= lss_pkg::IO_KEY_W'(mem_rd_data);
          if (func_r == lss_pkg::OP_POP) begin
            count_r <= count_m1;
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_SRCH: begin
          priority if (hit) begin
            position_r  <= lss_pkg::POS_W'(pos_r);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (last) begin
            status_r    <= lss_pkg::ST_NOTFOUND;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            // advance one entry down the stack
            pos_r       <= pos_r + AW'(1);
            next_addr_r <= next_addr_r - AW'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_data     = data_r;
  assign out_position = position_r;
  assign out_count    = lss_pkg::COUNT_W'(count_r);

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("fill count beyond stack depth");

  a_no_word_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result word shown while operation still in flight");

  a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == lss_pkg::OP_PUSH && !full) |=>
      (out_valid && count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not add one entry");

  a_search_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (pos_r < count_r[AW-1:0] || full))
    else $error("search walked past the bottom of the stack");

  a_pop_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && func_r == lss_pkg::OP_POP) |=>
      (out_valid && count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not remove one entry");

endmodule

`default_nettype wire

@@ tb/lifo_stack_with_search_checker.sv @@
// Checker for the LIFO stack unit: predicts each result word and compares it on arrival.
module lifo_stack_with_search_checker #(
  parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic                                busy,
  input  wire logic [lss_pkg::FUNC_W-1:0]          in_func,
  input  wire logic [lss_pkg::IO_KEY_W-1:0]        in_key,
  input  wire logic                                out_valid,
  input  wire logic [lss_pkg::STATUS_W-1:0]        out_status,
  input  wire logic [lss_pkg::IO_KEY_W-1:0]        out_data,
  input  wire logic [lss_pkg::POS_W-1:0]           out_position,
  input  wire logic [lss_pkg::COUNT_W-1:0]         out_count,
  output int unsigned                              fail_count,
  output int unsigned                              words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lss_pkg::*;

  typedef struct packed {
    status_t                    status;
    logic [IO_KEY_W-1:0]        data;
    logic [POS_W-1:0]           position;
    logic [COUNT_W-1:0]         count;
  } stack_word_t;

  // Shadow of the stack contents and its fill level.
  logic [IO_KEY_W-1:0] key_store [DEPTH];
  int unsigned         fill_level;
  stack_word_t         expected_words [$];
  int unsigned         errs;

  initial begin
    fill_level    = 0;
    errs          = 0;
    fail_count    = 0;
    words_pending = 0;
  end

  // Apply one request to the shadow stack and return the word it must produce.
  function automatic stack_word_t apply_request(logic [FUNC_W-1:0] func,
                                                logic [IO_KEY_W-1:0] key);
    stack_word_t w;
    bit          hit;
    w.status   = ST_OK;
    w.data     = '0;
    w.position = '0;
    hit        = 1'b0;
    case (func)
      OP_PUSH: begin
        if (fill_level >= DEPTH) begin
          w.status = ST_FULL;
        end else begin
          key_store[fill_level] = key;
          fill_level++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (fill_level == 0) begin
          w.status = ST_EMPTY;
        end else begin
          w.data = key_store[fill_level-1];
          if (func == OP_POP) fill_level--;
        end
      end
      OP_CLEAR: fill_level = 0;
      OP_SEARCH: begin
        w.status = ST_NOTFOUND;
        // walk from the top down, stop at the first match
        for (int i = 0; i < int'(fill_level) && !hit; i++) begin
          if (key_store[int'(fill_level)-1-i] == key) begin
            hit        = 1'b1;
            w.status   = ST_OK;
            w.position = i[POS_W-1:0];
          end
        end
      end
      default: ;
    endcase
    w.count = fill_level[COUNT_W-1:0];
    return w;
  endfunction

  task automatic check_field(string name, logic [IO_KEY_W-1:0] want,
                             logic [IO_KEY_W-1:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    stack_word_t w;
    if (!rst_n) begin
      expected_words.delete();
      fill_level = 0;
    end else begin
      // retire the result word first; it always belongs to an older request
      if (out_valid !== 1'b0) begin
        if (expected_words.size() == 0) begin
          errs++;
          $display("%0t: unexpected result word, expected none, got status %0h data %0h",
                   $time, out_status, out_data);
        end else begin
          w = expected_words.pop_front();
          check_field("status",   IO_KEY_W'(w.status),   IO_KEY_W'(out_status));
          check_field("data",     w.data,                out_data);
          check_field("position", IO_KEY_W'(w.position), IO_KEY_W'(out_position));
          check_field("count",    IO_KEY_W'(w.count),    IO_KEY_W'(out_count));
        end
      end
      if (start && !busy)
        expected_words.push_back(apply_request(in_func, in_key));
    end
    fail_count    <= errs;
    words_pending <= expected_words.size();
  end

endmodule

@@ tb/lifo_stack_with_search_unit_tb.sv @@
// Testbench top for the LIFO stack unit: reset, stimulus phases and the final verdict.
module lifo_stack_with_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lss_pkg::*;

  localparam int unsigned DEPTH     = DEPTH_DEF;
  localparam int unsigned LIMIT     = 1_000_000;
  // Function codes the block must ignore.
  localparam logic [FUNC_W-1:0] FUNC_RSVD_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_HI = 3'd7;

  logic                        clk      = 1'b0;
  logic                        rst_n    = 1'b0;
  logic                        start    = 1'b0;
  logic [FUNC_W-1:0]           in_func  = OP_COUNT;
  logic signed [IO_KEY_W-1:0]  in_key   = '0;
  logic                        busy;
  logic                        out_valid;
  logic [STATUS_W-1:0]         out_status;
  logic signed [IO_KEY_W-1:0]  out_data;
  logic [POS_W-1:0]            out_position;
  logic [COUNT_W-1:0]          out_count;
  int unsigned                 fail_count;
  int unsigned                 words_pending;
  int unsigned                 cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lifo_stack_with_search_unit #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH_DEF)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_position (out_position),
    .out_count    (out_count)
  );

  // The checker sees both channels and owns all prediction; the top only drives.
  lifo_stack_with_search_checker #(
    .DEPTH (DEPTH)
  ) stack_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_data      (out_data),
    .out_position  (out_position),
    .out_count     (out_count),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // Watchdog: a hung handshake or a lost word ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL lifo_stack_with_search_unit");
      $finish;
    end
  end

  // Draw a key: mostly from a small pool so searches hit and duplicates occur,
  // otherwise a full 32-bit random value so every key bit toggles.
  function automatic logic [IO_KEY_W-1:0] pick_key(int unsigned pool_pct);
    if ($urandom_range(99) < pool_pct) begin
      case ($urandom_range(7))
        0:       return 32'h7fff_ffff;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        3:       return 32'hffff_ffff;
        4:       return 32'h0000_0001;
        5:       return 32'h5a5a_5a5a;
        6:       return 32'ha5a5_a5a5;
        default: return 32'h0000_0100;
      endcase
    end
    return $urandom;
  endfunction

  // Weighted operation choice; what is left after push/pop/clear is shared by
  // search, peek, count and the two ignored codes.
  function automatic logic [FUNC_W-1:0] pick_func(int unsigned push_pct,
                                                  int unsigned pop_pct,
                                                  int unsigned clear_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct) return OP_PUSH;
    r -= push_pct;
    if (r < pop_pct) return OP_POP;
    r -= pop_pct;
    if (r < clear_pct) return OP_CLEAR;
    case ($urandom_range(9))
      0, 1, 2, 3: return OP_SEARCH;
      4, 5:       return OP_PEEK;
      6, 7:       return OP_COUNT;
      8:          return FUNC_RSVD_LO;
      default:    return FUNC_RSVD_HI;
    endcase
  endfunction

  // Present one word and hold it until the edge that accepts it. Before the
  // word, drop start for a random gap when the idle rate asks for one.
  task automatic issue(logic [FUNC_W-1:0] func, logic [IO_KEY_W-1:0] key,
                       int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    in_func <= func;
    in_key  <= key;
    @(posedge clk);
    // busy read here is the value before this edge, so this is the accept test
    while (busy) @(posedge clk);
  endtask

  // Hold off the sender until every predicted word has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned n_words, int unsigned idle_pct,
                           int unsigned push_pct, int unsigned pop_pct,
                           int unsigned clear_pct);
    logic [FUNC_W-1:0] func;
    for (int unsigned j = 0; j < n_words; j++) begin
      func = pick_func(push_pct, pop_pct, clear_pct);
      issue(func, pick_key(func == OP_PUSH ? 50 : 70), idle_pct);
    end
  endtask

  initial begin : stimulus
    int unsigned tail;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-stack behavior, ignored codes, extreme keys, search hits,
    // a duplicate key (first match from the top wins), misses and clear.
    issue(OP_POP,       32'h1234_5678, 0);
    issue(OP_PEEK,      32'h0,         0);
    issue(OP_SEARCH,    32'h0,         0);
    issue(OP_COUNT,     32'hffff_ffff, 0);
    issue(FUNC_RSVD_LO, 32'hdead_beef, 0);
    issue(FUNC_RSVD_HI, 32'h0,         0);
    issue(OP_PUSH,      32'h7fff_ffff, 0);
    issue(OP_PUSH,      32'h8000_0000, 0);
    issue(OP_PUSH,      32'h0000_0000, 0);
    issue(OP_PUSH,      32'hffff_ffff, 0);
    issue(OP_PEEK,      32'h0,         0);
    issue(OP_SEARCH,    32'h7fff_ffff, 0);
    issue(OP_SEARCH,    32'hffff_ffff, 0);
    issue(OP_SEARCH,    32'h1234_5678, 0);
    issue(OP_PUSH,      32'h7fff_ffff, 0);
    issue(OP_SEARCH,    32'h7fff_ffff, 0);
    issue(OP_POP,       32'h0,         0);
    issue(OP_POP,       32'h0,         0);
    issue(OP_SEARCH,    32'hffff_ffff, 0);
    issue(OP_COUNT,     32'h0,         0);
    issue(OP_CLEAR,     32'h0,         0);
    issue(OP_COUNT,     32'h0,         0);
    issue(OP_POP,       32'h0,         0);
    issue(OP_SEARCH,    32'h0,         0);
    drain();

    // Back-to-back, push heavy: fill the stack past DEPTH so full pushes,
    // deep searches and peeks from a full stack all occur.
    run_phase(300, 0, 93, 0, 0);
    drain();
    // Sparse sender: long gaps land on every cycle of a search walk.
    run_phase(150, 86, 45, 35, 2);
    drain();
    // Light gaps with a balanced mix around the empty end.
    run_phase(150, 25, 40, 40, 3);

    drain();
    // Watch a little longer for any stray word; a search walk is the longest.
    tail = 0;
    while (tail < DEPTH + 8) begin
      @(posedge clk);
      tail++;
    end
    if (fail_count == 0)
      $display("PASS lifo_stack_with_search_unit");
    else
      $display("FAIL lifo_stack_with_search_unit");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/lss_pkg.sv
rtl/core/lss_ram.sv
rtl/core/lifo_stack_with_search_unit.sv
tb/lifo_stack_with_search_checker.sv
tb/lifo_stack_with_search_unit_tb.sv
